/* sv/lwbpc_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes of the lru write-back page cache controller
// no dependencies

package lwbpc_pkg;

	localparam int CMD_W    = 2;
	localparam int PAGE_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int CNT_W    = 32;
	localparam int PIU_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS_FREE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS_EVICT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WR_REJECT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FLUSH_ENTRY = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FLUSH_EMPTY = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY    = 1'd1;

	localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

	typedef struct packed {
		logic                clear;
		logic                read_only;
		logic [PIU_W-1:0]    pages_in_use;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [PAGE_W-1:0]   victim_page;
		logic                writeback;
		logic                last;
		logic [CNT_W-1:0]    request_count;
		logic [CNT_W-1:0]    miss_count;
	} result_t;

endpackage

/* sv/lwbpc_in_if.sv */
`timescale 1ns / 1ps
// access command channel: valid/ready plus command and page number
// depends on lwbpc_pkg

interface lwbpc_in_if;
	logic                         valid;
	logic                         ready;
	logic [lwbpc_pkg::CMD_W-1:0]  command;
	logic [lwbpc_pkg::PAGE_W-1:0] page_number;

	modport source (output valid, command, page_number, input ready);
	modport sink (input valid, command, page_number, output ready);
endinterface

/* sv/lwbpc_out_if.sv */
`timescale 1ns / 1ps
// result channel: valid/ready plus the result word fields
// depends on lwbpc_pkg

interface lwbpc_out_if;
	logic                           valid;
	logic                           ready;
	logic [lwbpc_pkg::STATUS_W-1:0] status;
	logic [lwbpc_pkg::SLOT_W-1:0]   slot;
	logic [lwbpc_pkg::PAGE_W-1:0]   victim_page;
	logic                           writeback;
	logic                           last;
	logic [lwbpc_pkg::CNT_W-1:0]    request_count;
	logic [lwbpc_pkg::CNT_W-1:0]    miss_count;

	modport source (output valid, status, slot, victim_page, writeback, last,
		request_count, miss_count, input ready);
	modport sink (input valid, status, slot, victim_page, writeback, last,
		request_count, miss_count, output ready);
endinterface

/* sv/lwbpc_ram.sv */
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module lwbpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/lwbpc_ctrl.sv */
`timescale 1ns / 1ps
// tag search, recency update and flush sequencer over the slot ram
// depends on lwbpc_pkg, lwbpc_in_if and lwbpc_ram

module lwbpc_ctrl #(
	parameter int CACHE_PAGES      = 16,
	parameter int PAGE_NUMBER_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lwbpc_pkg::cfg_t    cfg,
	lwbpc_in_if.sink           access,
	output logic               res_valid,
	output lwbpc_pkg::result_t res,
	input  logic               res_ready
);
	import lwbpc_pkg::*;

	localparam int N   = CACHE_PAGES;
	localparam int IW  = $clog2(N);
	localparam int RW  = IW;
	localparam int CW  = $clog2(N + 1);
	localparam int TW  = PAGE_NUMBER_BITS;
	localparam int EW  = TW + RW;
	localparam int XW  = (CW > PIU_W) ? CW : PIU_W;
	localparam int PXW = (TW > PAGE_W) ? TW : PAGE_W;
	localparam int SXW = (IW > SLOT_W) ? IW : SLOT_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_UPDATE = 3'd2;
	localparam logic [2:0] S_FSCAN  = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       rd_cnt_q;
	logic                chk_vld_s1;
	logic [IW-1:0]       chk_idx_s1;
	logic [N-1:0]        valid_q;
	logic [N-1:0]        dirty_q;
	logic [CW-1:0]       alloc_q;
	logic [CNT_W-1:0]    lookup_q;
	logic [CNT_W-1:0]    miss_q;
	logic [TW-1:0]       page_q;
	logic                wr_q;
	logic                hit_q;
	logic [IW-1:0]       s_q;
	logic [RW-1:0]       hit_rank_q;
	logic [RW-1:0]       best_q;
	logic [IW-1:0]       lru_q;
	logic [TW-1:0]       lru_tag_q;
	logic                found_q;
	logic [TW-1:0]       min_tag_q;
	logic [RW-1:0]       limit_q;
	logic                age_all_q;
	logic                more_q;
	logic [STATUS_W-1:0] st_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PAGE_W-1:0]   victim_q;
	logic                wb_q;
	logic                last_q;

	logic                scan_active;
	logic                issue;
	logic                sweep_done;
	logic [EW-1:0]       rdata;
	logic [TW-1:0]       ent_tag;
	logic [RW-1:0]       ent_rank;
	logic                cur_v;
	logic                ram_we;
	logic [EW-1:0]       ram_wdata;
	logic [TW-1:0]       in_tag;
	logic [PXW-1:0]      pn_ext;
	logic [XW-1:0]       piu_x;
	logic [XW-1:0]       cap_x;
	logic                has_free;
	logic [N-1:0]        s_sel;
	logic [N-1:0]        dirty_left;
	logic [PXW-1:0]      lru_ext;
	logic [PXW-1:0]      min_ext;
	logic [SXW-1:0]      s_ext;
	logic [SXW-1:0]      lru_sext;
	logic [SXW-1:0]      alloc_sext;
	logic [SXW-1:0]      min_sext;

	assign scan_active = (state_q == S_SCAN) || (state_q == S_UPDATE) || (state_q == S_FSCAN);
	assign issue       = scan_active && (rd_cnt_q < CW'(N));
	assign sweep_done  = scan_active && !issue && !chk_vld_s1;
	assign ent_tag     = rdata[RW +: TW];
	assign ent_rank    = rdata[RW-1:0];
	assign cur_v       = valid_q[chk_idx_s1];

	// page number masked to the tag width
	assign pn_ext = PXW'(access.page_number);
	assign in_tag = pn_ext[TW-1:0];

	// capacity clamped to 2..CACHE_PAGES
	assign piu_x    = XW'(cfg.pages_in_use);
	assign cap_x    = (piu_x < XW'(2)) ? XW'(2) : ((piu_x > XW'(N)) ? XW'(N) : piu_x);
	assign has_free = (XW'(alloc_q) < cap_x);

	assign lru_ext    = PXW'(lru_tag_q);
	assign min_ext    = PXW'(min_tag_q);
	assign lru_sext   = SXW'(lru_q);
	assign alloc_sext = SXW'(alloc_q[IW-1:0]);
	assign s_ext      = SXW'(s_q);
	assign min_sext   = SXW'(chk_idx_s1);

	// second pass: age the more recent pages, install the accessed one at rank zero
	assign ram_we = (state_q == S_UPDATE) && chk_vld_s1 &&
		((chk_idx_s1 == s_q) || (cur_v && (age_all_q || (ent_rank < limit_q))));
	assign ram_wdata = (chk_idx_s1 == s_q) ? {page_q, RW'(0)} : {ent_tag, ent_rank + RW'(1)};

	assign s_sel      = {{(N-1){1'b0}}, 1'b1} << s_q;
	assign dirty_left = valid_q & dirty_q & ~s_sel;

	assign access.ready = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_EMIT);
	assign res = '{status: st_q, slot: slot_q, victim_page: victim_q, writeback: wb_q,
		last: last_q, request_count: lookup_q, miss_count: miss_q};

	lwbpc_ram #(.WIDTH(EW), .DEPTH(N)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (chk_idx_s1),
		.wdata (ram_wdata),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_cnt_q   <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			valid_q    <= '0;
			dirty_q    <= '0;
			alloc_q    <= '0;
			lookup_q   <= '0;
			miss_q     <= '0;
		end else if (cfg.clear) begin
			valid_q  <= '0;
			dirty_q  <= '0;
			alloc_q  <= '0;
			lookup_q <= '0;
			miss_q   <= '0;
		end else begin
			chk_vld_s1 <= issue;
			chk_idx_s1 <= rd_cnt_q[IW-1:0];
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					rd_cnt_q  <= '0;
					hit_q     <= 1'b0;
					best_q    <= '0;
					lru_q     <= '0;
					lru_tag_q <= '0;
					found_q   <= 1'b0;
					more_q    <= 1'b0;
					slot_q    <= '0;
					victim_q  <= '0;
					wb_q      <= 1'b0;
					last_q    <= 1'b1;
					page_q    <= in_tag;
					wr_q      <= (access.command == CMD_WRITE);
					if (access.valid) begin
						case (access.command)
							CMD_READ: state_q <= S_SCAN;
							CMD_WRITE: begin
								if (cfg.read_only) begin
									st_q    <= ST_WR_REJECT;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_FLUSH: begin
								if (cfg.read_only || !(|(valid_q & dirty_q))) begin
									st_q    <= ST_FLUSH_EMPTY;
									state_q <= S_EMIT;
								end else begin
									state_q <= S_FSCAN;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (chk_vld_s1 && cur_v) begin
						if (!hit_q && (ent_tag == page_q)) begin
							hit_q      <= 1'b1;
							s_q        <= chk_idx_s1;
							hit_rank_q <= ent_rank;
						end
						if (ent_rank >= best_q) begin
							best_q    <= ent_rank;
							lru_q     <= chk_idx_s1;
							lru_tag_q <= ent_tag;
						end
					end
					if (sweep_done) begin
						lookup_q  <= lookup_q + CNT_W'(1);
						rd_cnt_q  <= '0;
						age_all_q <= 1'b0;
						state_q   <= S_UPDATE;
						if (hit_q) begin
							st_q    <= ST_HIT;
							slot_q  <= s_ext[SLOT_W-1:0];
							limit_q <= hit_rank_q;
							if (wr_q) begin
								dirty_q[s_q] <= 1'b1;
							end
						end else begin
							miss_q <= miss_q + CNT_W'(1);
							if (has_free) begin
								s_q       <= alloc_q[IW-1:0];
								slot_q    <= alloc_sext[SLOT_W-1:0];
								st_q      <= ST_MISS_FREE;
								alloc_q   <= alloc_q + CW'(1);
								age_all_q <= 1'b1;
								valid_q[alloc_q[IW-1:0]] <= 1'b1;
								dirty_q[alloc_q[IW-1:0]] <= wr_q;
							end else begin
								s_q      <= lru_q;
								slot_q   <= lru_sext[SLOT_W-1:0];
								st_q     <= ST_MISS_EVICT;
								victim_q <= lru_ext[PAGE_W-1:0];
								wb_q     <= dirty_q[lru_q];
								limit_q  <= best_q;
								dirty_q[lru_q] <= wr_q;
							end
						end
					end
				end
				S_UPDATE: begin
					if (sweep_done) begin
						state_q <= S_EMIT;
					end
				end
				S_FSCAN: begin
					if (chk_vld_s1 && cur_v && dirty_q[chk_idx_s1] &&
						(!found_q || (ent_tag < min_tag_q))) begin
						found_q   <= 1'b1;
						s_q       <= chk_idx_s1;
						slot_q    <= min_sext[SLOT_W-1:0];
						min_tag_q <= ent_tag;
					end
					if (sweep_done) begin
						st_q     <= ST_FLUSH_ENTRY;
						victim_q <= min_ext[PAGE_W-1:0];
						wb_q     <= 1'b1;
						last_q   <= !(|dirty_left);
						more_q   <= |dirty_left;
						dirty_q[s_q] <= 1'b0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						state_q  <= more_q ? S_FSCAN : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/lru_write_back_page_cache_core.sv */
`timescale 1ns / 1ps
// lru write-back page cache tag controller, top level
// read/write access: result after a tag sweep, then a recency sweep on the ram
// flush: one ram sweep per dirty page listed, each sweep a minimum search
// rejected write, empty flush: no ram sweep; one command in flight, next taken once result is queued
// reset clears valid and dirty bits, counters and allocation at once; tag ram is not swept
// depends on lwbpc_pkg, lwbpc_in_if, lwbpc_out_if, lwbpc_ram, lwbpc_ctrl

module lru_write_back_page_cache_core #(
	parameter int CACHE_PAGES      = 16,
	parameter int PAGE_NUMBER_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lwbpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lwbpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	lwbpc_in_if.sink                            access,
	lwbpc_out_if.source                         result
);
	import lwbpc_pkg::*;

	// configuration registers
	logic [PIU_W-1:0] pages_in_use_q;
	logic             read_only_q;
	cfg_t             cfg;

	// result word from the sequencer and the output register
	logic             res_valid;
	result_t          res;
	logic             res_ready;
	logic             out_vld_q;
	result_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_in_use_q <= PIU_RESET;
			read_only_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGES_IN_USE: pages_in_use_q <= cfg_data[PIU_W-1:0];
				CFG_READ_ONLY:    read_only_q    <= cfg_data[0];
				default:          read_only_q    <= read_only_q;
			endcase
		end
	end

	// writing the slot count also wipes the table and the counters
	assign cfg = '{clear: cfg_we && (cfg_index == CFG_PAGES_IN_USE),
		read_only: read_only_q, pages_in_use: pages_in_use_q};

	lwbpc_ctrl #(
		.CACHE_PAGES      (CACHE_PAGES),
		.PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.access    (access),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register: a word may wait here while the sequencer moves on
	assign res_ready = !out_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.status        = out_q.status;
	assign result.slot          = out_q.slot;
	assign result.victim_page   = out_q.victim_page;
	assign result.writeback     = out_q.writeback;
	assign result.last          = out_q.last;
	assign result.request_count = out_q.request_count;
	assign result.miss_count    = out_q.miss_count;
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// testbench of lru_write_back_page_cache_core: directed table, then random accesses
// depends on lwbpc_pkg, lwbpc_in_if, lwbpc_out_if and the rtl under sv

module tb;
	import lwbpc_pkg::*;

	localparam int N_SLOTS = 16;
	// margin after results stop, covering the slowest command
	localparam int SETTLE = 80;
	// command code the block does not know
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef enum logic [1:0] {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [CMD_W-1:0]   command;
		logic [PAGE_W-1:0]  page;
		bit                 typed;
		result_t            want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lwbpc_in_if  access ();
	lwbpc_out_if result ();

	lru_write_back_page_cache_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.access    (access),
		.result    (result)
	);

	// own copy of the cache table
	logic [PAGE_W-1:0] tag_mem [N_SLOTS];
	bit                in_use  [N_SLOTS];
	bit                is_dirty[N_SLOTS];
	int                age     [N_SLOTS];
	int                filled;
	logic [CNT_W-1:0]  lookups;
	logic [CNT_W-1:0]  misses;
	int                cap_reg;
	bit                ro_reg;

	result_t pending_words[$];
	int      fail_count;
	int      send_idle_pct;
	int      recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#30ms;
		$display("tb: failure");
		$finish;
	end

	function automatic void table_clear();
		for (int i = 0; i < N_SLOTS; i++) begin
			in_use[i] = 1'b0;
			is_dirty[i] = 1'b0;
		end
		filled = 0;
		lookups = '0;
		misses = '0;
	endfunction

	function automatic result_t make_word(logic [STATUS_W-1:0] st, int s,
			logic [PAGE_W-1:0] vp, bit wb, bit lst);
		result_t w;
		w.status = st;
		w.slot = s[SLOT_W-1:0];
		w.victim_page = vp;
		w.writeback = wb;
		w.last = lst;
		w.request_count = lookups;
		w.miss_count = misses;
		return w;
	endfunction

	// move slot s to the front; slots younger than limit age by one
	function automatic void bump_to_front(int s, int limit);
		for (int i = 0; i < N_SLOTS; i++)
			if (in_use[i] && i != s && age[i] < limit)
				age[i]++;
		age[s] = 0;
	endfunction

	function automatic result_t lookup_page(logic [PAGE_W-1:0] pg, bit wr);
		int s;
		int oldest;
		int cap;
		logic [STATUS_W-1:0] st;
		logic [PAGE_W-1:0] vp;
		bit wb;
		s = -1;
		vp = '0;
		wb = 1'b0;
		cap = cap_reg < 2 ? 2 : (cap_reg > N_SLOTS ? N_SLOTS : cap_reg);
		lookups++;
		for (int i = 0; i < N_SLOTS; i++)
			if (s < 0 && in_use[i] && tag_mem[i] == pg)
				s = i;
		if (s >= 0) begin
			bump_to_front(s, age[s]);
			st = ST_HIT;
		end else begin
			misses++;
			if (filled < cap) begin
				s = filled;
				filled++;
				st = ST_MISS_FREE;
				in_use[s] = 1'b1;
				bump_to_front(s, 255);
			end else begin
				// least recent slot: highest rank, later index wins a tie
				oldest = 0;
				s = 0;
				for (int i = 0; i < N_SLOTS; i++)
					if (in_use[i] && age[i] >= oldest) begin
						oldest = age[i];
						s = i;
					end
				st = ST_MISS_EVICT;
				vp = tag_mem[s];
				wb = is_dirty[s];
				bump_to_front(s, oldest);
			end
			tag_mem[s] = pg;
			is_dirty[s] = 1'b0;
		end
		if (wr)
			is_dirty[s] = 1'b1;
		return make_word(st, s, vp, wb, 1'b1);
	endfunction

	// expected words of one accepted command
	function automatic void predict_command(logic [CMD_W-1:0] cmd,
			logic [PAGE_W-1:0] pg, ref result_t words[$]);
		int s;
		words.delete();
		case (cmd)
			CMD_READ: words.push_back(lookup_page(pg, 1'b0));
			CMD_WRITE: begin
				if (ro_reg)
					words.push_back(make_word(ST_WR_REJECT, 0, '0, 1'b0, 1'b1));
				else
					words.push_back(lookup_page(pg, 1'b1));
			end
			CMD_FLUSH: begin
				// list dirty pages, lowest page number first
				if (!ro_reg) begin
					do begin
						s = -1;
						for (int i = 0; i < N_SLOTS; i++)
							if (in_use[i] && is_dirty[i] &&
									(s < 0 || tag_mem[i] < tag_mem[s]))
								s = i;
						if (s >= 0) begin
							is_dirty[s] = 1'b0;
							words.push_back(make_word(ST_FLUSH_ENTRY, s, tag_mem[s],
								1'b1, 1'b0));
						end
					end while (s >= 0);
				end
				if (words.size() == 0)
					words.push_back(make_word(ST_FLUSH_EMPTY, 0, '0, 1'b0, 1'b1));
				else
					words[words.size()-1].last = 1'b1;
			end
			default: ; // unknown command: no word at all
		endcase
	endfunction

	// offer one command, idling first at the current rate, hold until taken
	task automatic send_command(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] pg,
			bit typed, result_t want);
		result_t words[$];
		while ($urandom_range(99) < send_idle_pct) begin
			access.valid <= 1'b0;
			access.command <= CMD_W'($urandom);
			access.page_number <= $urandom;
			@(posedge clk);
		end
		access.valid <= 1'b1;
		access.command <= cmd;
		access.page_number <= pg;
		do @(posedge clk); while (!access.ready);
		predict_command(cmd, pg, words);
		if (typed)
			pending_words.push_back(want);
		else
			foreach (words[i]) pending_words.push_back(words[i]);
	endtask

	// block has to be idle: all words back, then its longest latency
	task automatic wait_idle();
		access.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PAGES_IN_USE) begin
			cap_reg = val;
			table_clear();
		end else begin
			ro_reg = val[0];
		end
	endtask

	// receiver: random stall, compare every word taken with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: status %0d slot %0d", result.status, result.slot);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					fail_count++;
				end
				if (result.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, result.slot);
					fail_count++;
				end
				if (result.victim_page !== want.victim_page) begin
					$error("victim_page: expected %0h, got %0h", want.victim_page,
						result.victim_page);
					fail_count++;
				end
				if (result.writeback !== want.writeback) begin
					$error("writeback: expected %0d, got %0d", want.writeback,
						result.writeback);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					fail_count++;
				end
				if (result.request_count !== want.request_count) begin
					$error("request_count: expected %0d, got %0d", want.request_count,
						result.request_count);
					fail_count++;
				end
				if (result.miss_count !== want.miss_count) begin
					$error("miss_count: expected %0d, got %0d", want.miss_count,
						result.miss_count);
					fail_count++;
				end
			end
		end
		result.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic stim_row_t word_row(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] pg);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.command = cmd;
		r.page = pg;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] pg,
			logic [STATUS_W-1:0] st, int s, logic [PAGE_W-1:0] vp, bit wb,
			int req, int mis);
		stim_row_t r;
		r = word_row(cmd, pg);
		r.typed = 1'b1;
		r.want.status = st;
		r.want.slot = s[SLOT_W-1:0];
		r.want.victim_page = vp;
		r.want.writeback = wb;
		r.want.last = 1'b1;
		r.want.request_count = CNT_W'(req);
		r.want.miss_count = CNT_W'(mis);
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
		stim_row_t r;
		r = word_row(CMD_READ, '0);
		r.kind = ROW_CFG;
		r.command = CMD_W'(idx);
		r.page = PAGE_W'(val);
		return r;
	endfunction

	// random page: mostly a small pool so hits and evictions happen
	function automatic logic [PAGE_W-1:0] pick_page();
		int roll;
		roll = $urandom_range(99);
		if (roll < 75) return $urandom_range(23);
		if (roll < 80) return '1;
		if (roll < 85) return PAGE_W'($urandom_range(23)) | 32'hffff_ff00;
		return $urandom;
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45) return CMD_READ;
		if (roll < 85) return CMD_WRITE;
		if (roll < 96) return CMD_FLUSH;
		return CMD_NONE; // block ignores it
	endfunction

	initial begin
		stim_row_t rows[$];
		int cap_choice[8];
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cap_reg = 16;
		ro_reg = 1'b0;
		table_clear();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		access.valid = 1'b0;
		access.command = '0;
		access.page_number = '0;
		result.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: counters and slots after reset, extremes of page numbers
		rows.push_back(typed_row(CMD_READ, 32'h0, ST_MISS_FREE, 0, '0, 0, 1, 1));
		rows.push_back(typed_row(CMD_WRITE, 32'hffff_ffff, ST_MISS_FREE, 1, '0, 0, 2, 2));
		rows.push_back(typed_row(CMD_READ, 32'h0, ST_HIT, 0, '0, 0, 3, 2));
		rows.push_back(typed_row(CMD_FLUSH, 32'h0, ST_FLUSH_ENTRY, 1, '1, 1, 3, 2));
		rows.push_back(typed_row(CMD_FLUSH, 32'h1234, ST_FLUSH_EMPTY, 0, '0, 0, 3, 2));
		rows.push_back(word_row(CMD_NONE, 32'h5555_aaaa)); // unknown command, no word
		rows.push_back(word_row(CMD_WRITE, 32'h0));
		rows.push_back(word_row(CMD_WRITE, 32'haaaa_5555));
		rows.push_back(word_row(CMD_WRITE, 32'h3));
		rows.push_back(word_row(CMD_FLUSH, 32'h0)); // several entries, ascending
		// read-only: write rejected, flush empty even with dirty pages
		rows.push_back(word_row(CMD_WRITE, 32'h7));
		rows.push_back(cfg_row(CFG_READ_ONLY, 1));
		rows.push_back(typed_row(CMD_WRITE, 32'h7, ST_WR_REJECT, 0, '0, 0, 7, 5));
		rows.push_back(word_row(CMD_FLUSH, 32'h0));
		rows.push_back(word_row(CMD_READ, 32'h7));
		rows.push_back(cfg_row(CFG_READ_ONLY, 0));
		// smallest capacity: evictions, with and without writeback
		rows.push_back(cfg_row(CFG_PAGES_IN_USE, 2));
		rows.push_back(typed_row(CMD_WRITE, 32'h10, ST_MISS_FREE, 0, '0, 0, 1, 1));
		rows.push_back(word_row(CMD_READ, 32'h11));
		rows.push_back(word_row(CMD_READ, 32'h12));
		rows.push_back(word_row(CMD_READ, 32'h11));
		rows.push_back(word_row(CMD_WRITE, 32'h13));
		rows.push_back(word_row(CMD_READ, 32'h14));
		rows.push_back(word_row(CMD_READ, 32'h15));
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_reg(rows[i].command[CFG_IDX_W-1:0], rows[i].page[CFG_DATA_W-1:0]);
			else
				send_command(rows[i].command, rows[i].page, rows[i].typed, rows[i].want);
		end

		// random phases; capacity includes out of range codes that clamp
		cap_choice = '{16, 2, 0, 31, 5, 17, 1, 9};
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			write_reg(CFG_PAGES_IN_USE, CFG_DATA_W'(cap_choice[ph]));
			write_reg(CFG_READ_ONLY, (ph == 5) ? CFG_DATA_W'(1) : CFG_DATA_W'(0));
			for (int n = 0; n < 48; n++)
				send_command(pick_command(), pick_page(), 1'b0, '0);
			// read-only switched on with a warm table
			if (ph == 3) begin
				write_reg(CFG_READ_ONLY, CFG_DATA_W'(1));
				for (int n = 0; n < 8; n++)
					send_command(pick_command(), pick_page(), 1'b0, '0);
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
